/* sv/srng_pkg.sv */
package srng_pkg;

    localparam int unsigned VALUE_W       = 31;
    localparam int unsigned MUL_W         = 15;
    localparam int unsigned PROD_W        = VALUE_W + MUL_W;

    // Table size must be a power of two; the index is then the top bits of the last output.
    localparam int unsigned TABLE_ENTRIES = 32;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int unsigned WARMUP_STEPS  = 8;
    localparam int unsigned SEED_STEPS    = WARMUP_STEPS + TABLE_ENTRIES;
    localparam int unsigned STEP_W        = $clog2(SEED_STEPS);

    localparam logic [MUL_W-1:0]   MUL_A = MUL_W'(16807);
    localparam logic [VALUE_W-1:0] MOD_M = VALUE_W'(2147483647);

    localparam logic [STEP_W-1:0] STEP_FIRST_FILL = STEP_W'(WARMUP_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST       = STEP_W'(SEED_STEPS - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SMUL = 5'b00010,
        ST_SRED = 5'b00100,
        ST_DMUL = 5'b01000,
        ST_DRED = 5'b10000
    } state_t;

endpackage

/* sv/srng_ram.sv */
module srng_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/shuffled_park_miller_rng.sv */
// Shuffled minimal-standard random number generator.
// Input channel (s_valid/s_ready/s_restart): each transaction requests one draw;
// s_restart = 1 reseeds from the seed register and refills the shuffle table first.
// Output channel (m_valid/m_ready/m_value): one 31-bit value per request.
// Configuration: cfg_wr_en/cfg_wr_data write the seed; it takes effect at the next
// seeding. A seed of 0 or 2^31-1 starts the generator from 1.
// Flow: an ordinary draw goes from acceptance through ST_DRED to the output register.
// The 31x15 multiply of the generator state runs while the block waits for a request,
// and the draw cycle does the mod 2^31-1 fold and the table swap. A new request is
// accepted only in ST_IDLE, after the last draw is done. A seeding runs 40 generator
// steps (ST_SMUL, ST_SRED) on that multiplier; ST_DMUL then restarts it for the draw.
// The shuffle table sits in a 32-entry RAM with registered read; the entry
// index comes from the last output and is read the cycle the draw starts.
// Reset: the seed register returns to 1 and the block is unseeded, so the first
// request after reset always seeds, whatever s_restart says.
// Stall: the result sits in an output register; a new request is still taken
// while it waits, but that draw holds in its final cycle until the register frees.
module shuffled_park_miller_rng
    import srng_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [VALUE_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VALUE_W-1:0] m_value
);

    state_t              state_reg, state_next;
    logic [VALUE_W-1:0]  seed_reg;
    logic [VALUE_W-1:0]  g_reg, g_next;
    logic [VALUE_W-1:0]  last_reg, last_next;
    logic                seeded_reg, seeded_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PROD_W-1:0]   prod_reg;
    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  m_value_reg, m_value_next;

    logic [VALUE_W:0]    fold_sum;
    logic [VALUE_W-1:0]  g_adv;
    logic [VALUE_W-1:0]  seed_start;
    logic [IDX_W-1:0]    draw_idx;
    logic [STEP_W-1:0]   fill_pos;
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [VALUE_W-1:0]  ram_rd_data;
    logic                accept;
    logic                out_free;

    // Fold the 46-bit product: 2^31 == 1 mod M.
    assign fold_sum = (VALUE_W+1)'(prod_reg[PROD_W-1:VALUE_W])
                    + (VALUE_W+1)'(prod_reg[VALUE_W-1:0]);
    assign g_adv    = (fold_sum >= (VALUE_W+1)'(MOD_M))
                    ? VALUE_W'(fold_sum - (VALUE_W+1)'(MOD_M))
                    : VALUE_W'(fold_sum);

    assign seed_start = (seed_reg == '0 || seed_reg == MOD_M) ? VALUE_W'(1) : seed_reg;
    assign draw_idx   = last_reg[VALUE_W-1 -: IDX_W];
    assign fill_pos   = STEP_LAST - step_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;

    srng_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (g_adv),
        .rd_addr (draw_idx),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        g_next       = g_reg;
        last_next    = last_reg;
        seeded_next  = seeded_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = draw_idx;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_restart || !seeded_reg) begin
                        g_next     = seed_start;
                        step_next  = '0;
                        state_next = ST_SMUL;
                    end else begin
                        state_next = ST_DRED;
                    end
                end
            end
            ST_SMUL: begin
                state_next = ST_SRED;
            end
            ST_SRED: begin
                g_next      = g_adv;
                ram_wr_en   = (step_reg >= STEP_FIRST_FILL);
                ram_wr_addr = fill_pos[IDX_W-1:0];
                if (step_reg == STEP_LAST) begin
                    // entry 0 is filled last, so it is also the new last output
                    last_next   = g_adv;
                    seeded_next = 1'b1;
                    state_next  = ST_DMUL;
                end else begin
                    step_next  = step_reg + STEP_W'(1);
                    state_next = ST_SMUL;
                end
            end
            ST_DMUL: begin
                state_next = ST_DRED;
            end
            ST_DRED: begin
                // hold here until the output register frees
                if (out_free) begin
                    g_next       = g_adv;
                    last_next    = ram_rd_data;
                    ram_wr_en    = 1'b1;
                    m_valid_next = 1'b1;
                    m_value_next = ram_rd_data;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seed_reg    <= VALUE_W'(1);
            g_reg       <= VALUE_W'(1);
            last_reg    <= '0;
            seeded_reg  <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            g_reg       <= g_next;
            last_reg    <= last_next;
            seeded_reg  <= seeded_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    // The product only ever comes from the current generator state.
    always_ff @(posedge aclk) begin
        prod_reg    <= PROD_W'(g_reg) * PROD_W'(MUL_A);
        m_value_reg <= m_value_next;
    end

    a_seeded_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(seeded_reg) |-> seeded_reg)
        else $error("seeded flag dropped outside reset");

    a_gen_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        g_reg != '0 && g_reg != MOD_M)
        else $error("generator state collapsed to zero");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_value != '0 && m_value != MOD_M))
        else $error("result outside generator range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while a draw is in flight");

endmodule

/* bench/draw_checker.sv */
module draw_checker
    import srng_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [VALUE_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_restart,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [VALUE_W-1:0] m_value,
    output int                 fail_count,
    output int                 outstanding
);

    localparam longint unsigned MODULUS    = 64'(MOD_M);
    localparam longint unsigned MULTIPLIER = 64'(MUL_A);
    // Width of the slice of the output range that maps to one table entry.
    localparam int unsigned     ENTRY_SPAN = 1 + (32'd2147483646 / TABLE_ENTRIES);

    logic [VALUE_W-1:0] seed_reg;
    logic [VALUE_W-1:0] gen;
    logic [VALUE_W-1:0] last_out;
    logic [VALUE_W-1:0] shuffle [TABLE_ENTRIES];
    logic               seeded;
    logic [VALUE_W-1:0] expected_values [$];

    function automatic logic [VALUE_W-1:0] minstd_next(input logic [VALUE_W-1:0] g);
        longint unsigned prod;
        prod = (64'(g) * MULTIPLIER) % MODULUS;
        return VALUE_W'(prod);
    endfunction

    task automatic reseed_table();
        logic [VALUE_W-1:0] g;
        int                 n;
        g = seed_reg;
        // zero and the modulus itself would lock the generator at zero
        if (g == '0 || g == MOD_M) begin
            g = VALUE_W'(1);
        end
        repeat (WARMUP_STEPS) g = minstd_next(g);
        for (n = TABLE_ENTRIES - 1; n >= 0; n--) begin
            g = minstd_next(g);
            shuffle[n] = g;
        end
        gen      = g;
        last_out = shuffle[0];
        seeded   = 1'b1;
    endtask

    task automatic draw_value(input logic restart, output logic [VALUE_W-1:0] value);
        int unsigned j;
        if (restart || !seeded) begin
            reseed_table();
        end
        gen = minstd_next(gen);
        j = 32'(last_out) / ENTRY_SPAN;
        if (j >= TABLE_ENTRIES) begin
            j = TABLE_ENTRIES - 1;
        end
        last_out   = shuffle[j];
        shuffle[j] = gen;
        value      = last_out;
    endtask

    task automatic log_failure(input bit have_want, input logic [VALUE_W-1:0] want);
        if (fail_count < 10) begin
            if (have_want) begin
                $display("%0t: value mismatch: expected %0d, got %0d", $realtime, want, m_value);
            end else begin
                $display("%0t: unexpected value %0d, none expected", $realtime, m_value);
            end
        end
        fail_count++;
    endtask

    always @(posedge aclk) begin : monitor
        logic [VALUE_W-1:0] want;
        if (!aresetn) begin
            seed_reg = VALUE_W'(1);
            gen      = VALUE_W'(1);
            last_out = '0;
            seeded   = 1'b0;
            expected_values.delete();
        end else begin
            if (cfg_wr_en) begin
                seed_reg = cfg_wr_data;
            end
            // retire the oldest result before queuing a new draw
            if (m_valid && m_ready) begin
                if (expected_values.size() == 0) begin
                    log_failure(1'b0, '0);
                end else begin
                    want = expected_values.pop_front();
                    if (m_value !== want) begin
                        log_failure(1'b1, want);
                    end
                end
            end
            if (s_valid && s_ready) begin
                draw_value(s_restart, want);
                expected_values.push_back(want);
            end
        end
        outstanding = expected_values.size();
    end

endmodule

/* bench/testbench.sv */
module testbench
    import srng_pkg::*;
();

    localparam int HOLD_CYCLES = 300;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [VALUE_W-1:0] cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_restart   = 1'b0;
    logic               m_ready     = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic [VALUE_W-1:0] m_value;

    int   fail_count;
    int   outstanding;
    int   send_idle_pct = 10;
    int   recv_idle_pct = 65;
    logic hold_req      = 1'b0;

    always #6 aclk = ~aclk;

    shuffled_park_miller_rng u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value)
    );

    draw_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver: random backpressure, or a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_draw(input logic restart);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid   <= 1'b0;
            s_restart <= 1'($urandom_range(0, 1));
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_seed(input logic [VALUE_W-1:0] seed);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_random(input int count);
        int                 sent;
        int                 burst;
        int                 k;
        logic [VALUE_W-1:0] seed;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(15, 60);
            case ($urandom_range(0, 9))
                0: seed = '0;
                1: seed = MOD_M;
                2: seed = MOD_M - VALUE_W'(1);
                3: seed = VALUE_W'(1);
                default: seed = VALUE_W'($urandom);
            endcase
            drain();
            write_seed(seed);
            for (k = 0; k < burst && sent < count; k++) begin
                // mostly reseed on the first draw of a burst, rarely mid-burst
                if (k == 0) begin
                    send_draw($urandom_range(0, 9) < 7);
                end else begin
                    send_draw($urandom_range(0, 99) < 4);
                end
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // first draw seeds itself from the reset seed
        send_draw(1'b0);
        repeat (3) send_draw(1'b0);
        send_draw(1'b1);
        drain();

        write_seed('0);
        send_draw(1'b1);
        send_draw(1'b0);
        drain();

        write_seed(MOD_M);
        send_draw(1'b1);
        send_draw(1'b0);
        drain();

        write_seed(MOD_M - VALUE_W'(1));
        send_draw(1'b1);
        drain();

        // new seed stays dormant until the next restart
        write_seed(VALUE_W'(31'h2AAA_5555));
        repeat (2) send_draw(1'b0);
        send_draw(1'b1);
        send_draw(1'b0);
        drain();

        // stall the output long enough to back up the input
        hold_req = 1'b1;
        repeat (6) send_draw(1'b0);
        drain();

        run_random(220);

        send_idle_pct = 65;
        recv_idle_pct = 10;
        run_random(220);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(220);

        drain();
        repeat (120) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
